// ===== rtl/core/pmpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmpcc_pkg: shared types and constants of the PMP region configuration checker
// Holds the request and response transaction layouts, status and mode codes,
// configuration byte positions and the status word of the remainder unit.
// ----------------------------------------------------------------------------
package pmpcc_pkg;

  localparam int ADDR_BITS = 32;
  localparam int WORD_BITS = 30;

  // Address matching modes.
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_TOR   = 2'd1;
  localparam logic [1:0] MODE_NA4   = 2'd2;
  localparam logic [1:0] MODE_NAPOT = 2'd3;

  // Result status codes; the first failing check wins.
  localparam logic [2:0] STATUS_OK           = 3'd0;
  localparam logic [2:0] STATUS_NO_SIZE      = 3'd1;
  localparam logic [2:0] STATUS_NO_END       = 3'd2;
  localparam logic [2:0] STATUS_MISALIGNED   = 3'd3;
  localparam logic [2:0] STATUS_BAD_REGION   = 3'd4;
  localparam logic [2:0] STATUS_BELOW_GRAIN  = 3'd5;
  localparam logic [2:0] STATUS_LOCKED       = 3'd6;
  localparam logic [2:0] STATUS_BAD_RW       = 3'd7;

  // Configuration register indexes (byte address 4 * index).
  localparam logic REG_LOCK_BYPASS      = 1'b0;
  localparam logic REG_MACHINE_LOCKDOWN = 1'b1;

  typedef struct packed {
    logic [4:0]           region;
    logic [1:0]           mode;
    logic                 perm_read;
    logic                 perm_write;
    logic                 perm_exec;
    logic                 lock_bit;
    logic                 shared_bit;
    logic [ADDR_BITS-1:0] start_addr;
    logic [ADDR_BITS-1:0] end_addr;
    logic [ADDR_BITS-1:0] size;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [7:0]           cfg_byte;
    logic [WORD_BITS-1:0] addr_word;
    logic                 prev_written;
    logic [WORD_BITS-1:0] prev_addr_word;
  } rsp_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_status_t;

endpackage

// ===== rtl/core/pmpcc_mod_check.sv =====
// ----------------------------------------------------------------------------
// pmpcc_mod_check: bit-serial remainder unit
// Computes dividend modulo divisor by restoring division, one quotient bit
// per cycle, and reports whether the remainder is zero.
// ----------------------------------------------------------------------------
module pmpcc_mod_check import pmpcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [ADDR_BITS-1:0] dividend,
  input  logic [ADDR_BITS-1:0] divisor,
  output div_status_t          stat
);

  logic [ADDR_BITS-1:0] dvd;
  logic [ADDR_BITS-1:0] dvs;
  logic [ADDR_BITS-1:0] rem;
  logic [5:0]           cnt;
  logic                 done;
  logic [ADDR_BITS:0]   shifted;
  logic [ADDR_BITS:0]   diff;

  // The partial remainder stays below the divisor, so one trial subtract a
  // step keeps it in range.
  always_comb begin
    shifted = {rem, dvd[ADDR_BITS-1]};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= 6'(ADDR_BITS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[ADDR_BITS-2:0], 1'b0};
      rem <= diff[ADDR_BITS] ? shifted[ADDR_BITS-1:0] : diff[ADDR_BITS-1:0];
    end
  end

  always_comb begin
    stat.done     = done;
    stat.rem_zero = (rem == '0);
  end

endmodule

// ===== rtl/core/pmp_region_config_checker_unit.sv =====
// ----------------------------------------------------------------------------
// pmp_region_config_checker_unit: PMP region configuration checker
// Validates region configuration requests, keeps the per-region lock state
// and returns the encoded configuration byte and address words.
// ----------------------------------------------------------------------------
// Usage: a request transaction (req_valid/req_stall, payload req) carries one
// region configuration. The block answers each request with exactly one
// response transaction (rsp_valid/rsp_stall, payload rsp) holding the status,
// the packed configuration byte and the encoded address word(s).
// Timing: a request is taken only while the block is idle. Its response is
// presented once the bit-serial remainder unit that checks power-of-two
// alignment is done, one dividend bit per cycle over 32 bits. The response
// sits in an output register, so the next request is accepted while a
// stalled response still waits; if the receiver keeps stalling, the
// following request completes its checks and then holds until the output
// register frees up.
// Reset (synchronous, active high) clears all lock bits, both control
// registers and the handshake state. Control registers lock_bypass and
// machine_lockdown sit on the APB port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module pmp_region_config_checker_unit import pmpcc_pkg::*; #(
  parameter int REGION_COUNT = 16,
  parameter int GRAIN_LOG    = 0
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  // Response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W      = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int GRAN_SHIFT = GRAIN_LOG + 2;

  typedef enum logic {ST_IDLE, ST_WORK} state_t;

  state_t                  state;
  req_t                    req_q;
  rsp_t                    rsp_next;
  logic [REGION_COUNT-1:0] lock_bits;
  logic                    lock_bypass;
  logic                    machine_lockdown;
  div_status_t             div_stat;
  logic                    req_accept;
  logic                    out_free;
  logic                    finish;
  logic [6:0]              region_ext;
  logic [IDX_W-1:0]        region_idx;
  logic                    region_ok;
  logic                    locked;
  logic [ADDR_BITS-1:0]    extent;
  logic [WORD_BITS-1:0]    napot_s;
  logic [WORD_BITS-1:0]    napot_word;
  logic                    reg_idx;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied
  // high so no access is ever extended by wait states.
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_bypass      <= 1'b0;
      machine_lockdown <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_LOCK_BYPASS:      lock_bypass      <= pwdata[0];
        REG_MACHINE_LOCKDOWN: machine_lockdown <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOCK_BYPASS:      prdata = {31'b0, lock_bypass};
      REG_MACHINE_LOCKDOWN: prdata = {31'b0, machine_lockdown};
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake. A request is taken only in the idle state; the remainder unit
  // starts on the same edge with the start address and size straight from
  // the port.
  // --------------------------------------------------------------------------
  assign req_stall  = (state != ST_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign finish     = (state == ST_WORK) && div_stat.done && out_free;

  pmpcc_mod_check u_mod_check (
    .clk      (clk),
    .rst      (rst),
    .start    (req_accept),
    .dividend (req.start_addr),
    .divisor  (req.size),
    .stat     (div_stat)
  );

  // --------------------------------------------------------------------------
  // Checks and encoding, evaluated once the alignment remainder is known.
  // --------------------------------------------------------------------------
  always_comb begin
    region_ext = {2'b00, req_q.region};
    region_idx = region_ext[IDX_W-1:0];
    region_ok  = (region_ext < 7'(REGION_COUNT));
    locked     = region_ok && lock_bits[region_idx];

    // Extent of the region in bytes; top of range wraps modulo 2^32.
    unique case (req_q.mode)
      MODE_TOR: extent = req_q.end_addr - req_q.start_addr;
      MODE_NA4: extent = ADDR_BITS'(4);
      default:  extent = req_q.size;
    endcase

    // Power-of-two word: clear the size bit and fill the trailing ones. A size
    // below eight makes the fill wrap to all ones.
    napot_s    = WORD_BITS'(req_q.size >> 3);
    napot_word = (req_q.start_addr[ADDR_BITS-1:2] & ~napot_s) | (napot_s - 1'b1);

    rsp_next = '0;
    priority if (req_q.mode == MODE_NAPOT && req_q.size == '0) begin
      rsp_next.status = STATUS_NO_SIZE;
    end else if (req_q.mode == MODE_TOR && req_q.end_addr == '0) begin
      rsp_next.status = STATUS_NO_END;
    end else if (req_q.mode == MODE_NAPOT && !div_stat.rem_zero) begin
      rsp_next.status = STATUS_MISALIGNED;
    end else if (!region_ok) begin
      rsp_next.status = STATUS_BAD_REGION;
    end else if ((extent >> GRAN_SHIFT) == '0) begin
      rsp_next.status = STATUS_BELOW_GRAIN;
    end else if (locked && !lock_bypass) begin
      rsp_next.status = STATUS_LOCKED;
    end else if (!req_q.perm_read && req_q.perm_write && !machine_lockdown) begin
      rsp_next.status = STATUS_BAD_RW;
    end else begin
      rsp_next.status   = STATUS_OK;
      rsp_next.cfg_byte = {req_q.lock_bit, 1'b0, req_q.shared_bit, req_q.mode,
                           req_q.perm_exec, req_q.perm_write, req_q.perm_read};
      unique case (req_q.mode)
        MODE_TOR: begin
          rsp_next.addr_word = req_q.end_addr[ADDR_BITS-1:2];
          // Region zero has no lower neighbor to carry the start address.
          if (req_q.region != '0) begin
            rsp_next.prev_written   = 1'b1;
            rsp_next.prev_addr_word = req_q.start_addr[ADDR_BITS-1:2];
          end
        end
        MODE_NA4:   rsp_next.addr_word = req_q.start_addr[ADDR_BITS-1:2];
        MODE_NAPOT: rsp_next.addr_word = napot_word;
        default:    rsp_next.addr_word = '0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // State, response valid and the per-region lock bits. A successful write
  // stores the requested lock bit, which later requests to the region see.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      lock_bits <= '0;
    end else begin
      // A new response may enter the output register at the same edge the
      // previous one leaves it, so valid then simply stays high.
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_accept) begin
            state <= ST_WORK;
          end
        end
        ST_WORK: begin
          if (finish) begin
            state <= ST_IDLE;
            if (rsp_next.status == STATUS_OK) begin
              lock_bits[region_idx] <= req_q.lock_bit;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      req_q <= req;
    end
    if (finish) begin
      rsp <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  // The remainder unit restarts on every accepted request.
  a_div_restart: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> !div_stat.done)
    else $error("remainder unit did not restart on a new request");

  // A response only appears as the work state completes.
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_WORK) && state == ST_IDLE)
    else $error("response raised outside completion of a request");

  // A rejected request carries an all-zero payload.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STATUS_OK |->
      rsp.cfg_byte == '0 && rsp.addr_word == '0 && !rsp.prev_written &&
      rsp.prev_addr_word == '0)
    else $error("rejected response with nonzero payload");

  // The neighbor word is only written by an accepted top-of-range request.
  a_prev_tor: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.prev_written |->
      rsp.status == STATUS_OK && rsp.cfg_byte[4:3] == MODE_TOR)
    else $error("previous address word written outside top of range");
`endif

endmodule
